### rtl/ultrasonic_pan_tilt_tracker_core_assert.svh
// Assertion macros used by the tracker checker.
`ifndef ULTRASONIC_PAN_TILT_TRACKER_CORE_ASSERT_SVH
`define ULTRASONIC_PAN_TILT_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define UPTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define UPTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/uptt_pkg.sv
// Types and constants of the ultrasonic pan/tilt tracker.
`timescale 1ns / 1ps
`default_nettype none
package uptt_pkg;

	localparam int CNT_W    = 24;
	localparam int DIST_W   = 12;
	localparam int POS_W    = 13;
	localparam int STEP_W   = 6;
	localparam int MATCH_W  = 21;
	localparam int SENSOR_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	// count / 6800 = (count >> 4) / 425, done as a multiply by ceil(2^29 / 425)
	localparam int DIST_PRE_SHIFT = 4;
	localparam int DIST_IN_W      = CNT_W - DIST_PRE_SHIFT;
	localparam int DIST_RECIP_W   = 21;
	localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 21'd1263226;
	localparam int DIST_SHIFT     = 29;
	localparam int DIST_PROD_W    = DIST_IN_W + DIST_RECIP_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH    = 3'd5;

	localparam logic [DIST_W-1:0] THRESHOLD_RST = 12'd35;
	localparam logic [STEP_W-1:0] STEP_RST      = 6'd3;
	localparam logic [DIST_W-1:0] X_LOW_RST     = 12'd1000;
	localparam logic [DIST_W-1:0] X_HIGH_RST    = 12'd1600;
	localparam logic [DIST_W-1:0] Y_LOW_RST     = 12'd1600;
	localparam logic [DIST_W-1:0] Y_HIGH_RST    = 12'd2000;
	localparam logic [POS_W-1:0]  POS_RST       = 13'd1500;

	// sensor codes
	localparam logic [SENSOR_W-1:0] SENSOR_X0 = 2'd0;
	localparam logic [SENSOR_W-1:0] SENSOR_X1 = 2'd1;
	localparam logic [SENSOR_W-1:0] SENSOR_Y1 = 2'd2;
	localparam logic [SENSOR_W-1:0] SENSOR_Y0 = 2'd3;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd3
	} dir_t;

	typedef struct packed {
		logic              echo_ready;
		logic [CNT_W-1:0]  pulse_count;
	} in_item_t;

	typedef struct packed {
		logic                trigger_valid;
		logic [SENSOR_W-1:0] sensor_select;
		logic [DIST_W-1:0]   distance_reading;
		logic [POS_W-1:0]    servo_x_position;
		logic [POS_W-1:0]    servo_y_position;
		logic [MATCH_W-1:0]  servo_x_match;
		logic [MATCH_W-1:0]  servo_y_match;
	} out_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] lo;
		logic [DIST_W-1:0] hi;
		logic [STEP_W-1:0] step;
	} servo_cfg_t;

endpackage
`default_nettype wire

### rtl/uptt_servo.sv
// One servo axis: position, last direction and last accepted pair minimum.
`timescale 1ns / 1ps
`default_nettype none
module uptt_servo (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       fall_is_up,
	input  wire logic                       gate,
	input  wire logic [uptt_pkg::DIST_W-1:0] cur,
	input  wire uptt_pkg::servo_cfg_t       cfg,
	output logic      [uptt_pkg::POS_W-1:0] pos_next
);
	import uptt_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [DIST_W-1:0] prev_q;
	dir_t              dir_q;

	logic [DIST_W-1:0]        prev_n;
	dir_t                     dir_n;
	logic signed [DIST_W:0]   diff;
	logic                     rise, fall, want_up, want_dn, up_ok, dn_ok;
	logic [POS_W-1:0]         step_ext, pos_up, pos_dn;

	assign diff     = $signed({1'b0, cur}) - $signed({1'b0, prev_q});
	assign rise     = diff > 13'sd1;
	assign fall     = diff < -13'sd1;
	assign want_up  = fall_is_up ? fall : rise;
	assign want_dn  = fall_is_up ? rise : fall;
	assign up_ok    = pos_q < {1'b0, cfg.hi};
	assign dn_ok    = pos_q > {1'b0, cfg.lo};
	assign step_ext = {{(POS_W-STEP_W){1'b0}}, cfg.step};
	assign pos_up   = pos_q + step_ext;
	assign pos_dn   = (pos_q >= step_ext) ? (pos_q - step_ext) : '0;

	always_comb begin
		pos_next = pos_q;
		prev_n   = prev_q;
		dir_n    = dir_q;
		if (want_up && up_ok) begin
			dir_n  = DIR_UP;
			prev_n = cur;
			if (gate) pos_next = pos_up;
		end else if (want_dn && dn_ok) begin
			dir_n  = DIR_DOWN;
			prev_n = cur;
			if (gate) pos_next = pos_dn;
		end else if (gate) begin
			// keep moving the way we last went
			if (dir_q == DIR_UP && up_ok) pos_next = pos_up;
			else if (dir_q == DIR_DOWN && dn_ok) pos_next = pos_dn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_RST;
			prev_q <= '0;
			dir_q  <= DIR_NONE;
		end else if (en) begin
			pos_q  <= pos_next;
			prev_q <= prev_n;
			dir_q  <= dir_n;
		end
	end

endmodule
`default_nettype wire

### rtl/ultrasonic_pan_tilt_tracker_core.sv
// Top level of the ultrasonic pan/tilt tracker.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   tick channel (tick_valid / tick_stall / tick): one control-loop tick per
//   request, carrying echo_ready and the 24-bit echo pulse count.
//   result channel (result_valid / result_stall / result): exactly one result
//   per tick, in order: trigger flag, sensor to trigger next, distance
//   (count / 6800), both servo positions and their PWM match values.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes; cfg_ready is always high. Write only while no tick is in flight.
// Timing:
//   Four register stages: input, distance (reciprocal multiply), state update
//   (slot round-robin, distance store, servo step), PWM match (position
//   multiply).
//   One tick per cycle sustained while result_stall is low; the state update
//   stage is the only place that reads and writes loop state.
// Reset:
//   arst_n clears all stages to empty, restores register defaults, puts the
//   round-robin on its last slot and both servos at 1500 us.
// Stall:
//   A stalled result holds; stages behind it keep filling bubbles, and
//   tick_stall rises only once every stage holds a request.
module ultrasonic_pan_tilt_tracker_core #(
	parameter int SLOTS_PER_SENSOR = 10,
	parameter int PWM_PERIOD       = 1600000,
	parameter int CLOCKS_PER_US    = 80
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           tick_valid,
	output logic                                tick_stall,
	input  wire uptt_pkg::in_item_t             tick,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output uptt_pkg::out_item_t                 result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [uptt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [uptt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uptt_pkg::*;

	localparam int SUB_W  = (SLOTS_PER_SENSOR > 1) ? $clog2(SLOTS_PER_SENSOR) : 1;
	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SLOTS_PER_SENSOR - 1);
	localparam int CLK_W  = $clog2(CLOCKS_PER_US + 1);
	localparam int PER_W  = $clog2(PWM_PERIOD + 1);
	localparam int USED_W = POS_W + CLK_W + 1;
	localparam int CMP_A  = (USED_W > PER_W) ? USED_W : PER_W;
	localparam int CMP_W  = (CMP_A > MATCH_W) ? CMP_A : MATCH_W;

	// PWM match: period minus position in clocks minus one, clamped at zero
	function automatic logic [MATCH_W-1:0] match_of(input logic [POS_W-1:0] p);
		logic [CMP_W-1:0] used;
		logic [CMP_W-1:0] per;
		used = CMP_W'(p) * CMP_W'(CLOCKS_PER_US) + CMP_W'(1);
		per  = CMP_W'(PWM_PERIOD);
		return (used > per) ? '0 : MATCH_W'(per - used);
	endfunction

	// configuration registers
	logic [DIST_W-1:0] threshold_q, x_low_q, x_high_q, y_low_q, y_high_q;
	logic [STEP_W-1:0] step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			step_q      <= STEP_RST;
			x_low_q     <= X_LOW_RST;
			x_high_q    <= X_HIGH_RST;
			y_low_q     <= Y_LOW_RST;
			y_high_q    <= Y_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
				CFG_X_LOW:     x_low_q     <= cfg_data;
				CFG_X_HIGH:    x_high_q    <= cfg_data;
				CFG_Y_LOW:     y_low_q     <= cfg_data;
				CFG_Y_HIGH:    y_high_q    <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// stage valids and advance chain: a stage takes a request when it is
	// empty or its content moves on in the same cycle
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3, load4;

	assign load4      = !result_valid || !result_stall;
	assign rdy3       = !v3_q || load4;
	assign rdy2       = !v2_q || rdy3;
	assign rdy1       = !v1_q || rdy2;
	assign tick_stall = !rdy1;

	// stage 1: input register
	in_item_t tick_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_q <= 1'b0;
		else if (rdy1) v1_q <= tick_valid;
	end

	always_ff @(posedge clk) begin
		if (tick_valid && rdy1) tick_s1 <= tick;
	end

	// stage 2: distance through the reciprocal multiply
	logic [DIST_PROD_W-1:0] dist_prod;
	logic                   ready_s2;
	logic [DIST_W-1:0]      dist_s2;

	assign dist_prod = DIST_PROD_W'(tick_s1.pulse_count[CNT_W-1:DIST_PRE_SHIFT]) *
		DIST_PROD_W'(DIST_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_q <= 1'b0;
		else if (rdy2) v2_q <= v1_q;
	end

	always_ff @(posedge clk) begin
		if (v1_q && rdy2) begin
			ready_s2 <= tick_s1.echo_ready;
			dist_s2  <= dist_prod[DIST_SHIFT +: DIST_W];
		end
	end

	// stage 3: round-robin, distance store and servo update
	logic                upd;
	logic [SUB_W-1:0]    sub_q, sub_n;
	logic [SENSOR_W-1:0] sensor_q, sensor_n;
	logic [DIST_W-1:0]   sdist_q [4];
	logic [DIST_W-1:0]   sdist_n [4];
	logic                gate_x, gate_y;
	logic [DIST_W-1:0]   min_y_pair, min_x_pair;
	logic [POS_W-1:0]    pos_x_n, pos_y_n;
	servo_cfg_t          cfg_x, cfg_y;

	assign upd = v2_q && rdy3;

	always_comb begin
		sub_n    = sub_q;
		sensor_n = sensor_q;
		if (ready_s2) begin
			// advance one slot; the sensor changes after its last slot
			if (sub_q == SUB_LAST) begin
				sub_n    = '0;
				sensor_n = sensor_q + 2'd1;
			end else begin
				sub_n = sub_q + SUB_W'(1);
			end
		end
		for (int i = 0; i < 4; i++) begin
			sdist_n[i] = (ready_s2 && sensor_n == SENSOR_W'(i)) ? dist_s2 : sdist_q[i];
		end
	end

	assign gate_x     = (sdist_n[SENSOR_X0] > threshold_q) || (sdist_n[SENSOR_X1] > threshold_q);
	assign gate_y     = (sdist_n[SENSOR_Y1] > threshold_q) || (sdist_n[SENSOR_Y0] > threshold_q);
	assign min_y_pair = (sdist_n[SENSOR_Y0] < sdist_n[SENSOR_Y1]) ?
		sdist_n[SENSOR_Y0] : sdist_n[SENSOR_Y1];
	assign min_x_pair = (sdist_n[SENSOR_X0] < sdist_n[SENSOR_X1]) ?
		sdist_n[SENSOR_X0] : sdist_n[SENSOR_X1];
	assign cfg_x = '{lo: x_low_q, hi: x_high_q, step: step_q};
	assign cfg_y = '{lo: y_low_q, hi: y_high_q, step: step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= SUB_LAST;
			sensor_q <= SENSOR_Y0;
			for (int i = 0; i < 4; i++) sdist_q[i] <= '0;
		end else if (upd) begin
			sub_q    <= sub_n;
			sensor_q <= sensor_n;
			for (int i = 0; i < 4; i++) sdist_q[i] <= sdist_n[i];
		end
	end

	// x follows the y pair (a falling minimum steps it up), y the x pair
	uptt_servo u_servo_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (upd),
		.fall_is_up (1'b1),
		.gate       (gate_x),
		.cur        (min_y_pair),
		.cfg        (cfg_x),
		.pos_next   (pos_x_n)
	);

	uptt_servo u_servo_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (upd),
		.fall_is_up (1'b0),
		.gate       (gate_y),
		.cur        (min_x_pair),
		.cfg        (cfg_y),
		.pos_next   (pos_y_n)
	);

	logic                trig_s3;
	logic [SENSOR_W-1:0] sensor_s3;
	logic [DIST_W-1:0]   dist_s3;
	logic [POS_W-1:0]    pos_x_s3, pos_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_q <= 1'b0;
		else if (rdy3) v3_q <= v2_q;
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			trig_s3   <= ready_s2;
			sensor_s3 <= sensor_n;
			dist_s3   <= dist_s2;
			pos_x_s3  <= pos_x_n;
			pos_y_s3  <= pos_y_n;
		end
	end

	// stage 4: PWM match values into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else if (load4) result_valid <= v3_q;
	end

	always_ff @(posedge clk) begin
		if (v3_q && load4) begin
			result.trigger_valid    <= trig_s3;
			result.sensor_select    <= sensor_s3;
			result.distance_reading <= dist_s3;
			result.servo_x_position <= pos_x_s3;
			result.servo_y_position <= pos_y_s3;
			result.servo_x_match    <= match_of(pos_x_s3);
			result.servo_y_match    <= match_of(pos_y_s3);
		end
	end

endmodule
`default_nettype wire

### rtl/uptt_chk.sv
// Port-level checker for the tracker core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_pan_tilt_tracker_core_assert.svh"
module uptt_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                tick_stall,
	input wire logic                result_valid,
	input wire logic                result_stall,
	input wire uptt_pkg::out_item_t result
);
	import uptt_pkg::*;

	logic [SENSOR_W-1:0] last_sensor_q;
	logic                res_acc;
	logic                sensor_same, sensor_next;

	assign res_acc     = result_valid && !result_stall;
	assign sensor_same = result.sensor_select == last_sensor_q;
	assign sensor_next = result.sensor_select == last_sensor_q + 2'd1;

	// track the sensor of the last delivered result; reset selects the last sensor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_sensor_q <= SENSOR_Y0;
		else if (res_acc) last_sensor_q <= result.sensor_select;
	end

	`UPTT_ASSERT_NXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result), "stalled result changed or dropped")
	`UPTT_ASSERT_IMP(a_no_stall_when_empty, !result_valid, !tick_stall,
		"tick stalled while the result register is empty")
	`UPTT_ASSERT_IMP(a_sensor_hold, result_valid && !result.trigger_valid, sensor_same,
		"sensor changed on a tick without echo")
	`UPTT_ASSERT_IMP(a_sensor_advance, result_valid && result.trigger_valid,
		(sensor_same || sensor_next) && result.distance_reading <= 12'd2467,
		"sensor skipped or distance out of range on an echo tick")

endmodule

bind ultrasonic_pan_tilt_tracker_core uptt_chk u_uptt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_stall   (tick_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
